@@ rtl/jsq_pkg.sv @@
// Shared constants, types and codes for the join-shortest-queue dispatcher.
// Depends on nothing; imported by every module of the block.
package jsq_pkg;

    // Queue store geometry
    localparam int NUM_QUEUES  = 128;
    localparam int ADDR_W      = $clog2(NUM_QUEUES);
    localparam int QUEUE_W     = 7;
    localparam int COUNT_W     = 16;
    localparam int CFG_W       = 8;
    localparam int INDEX_REACH = 1 << QUEUE_W;
    localparam int SPAN_MAX    = (NUM_QUEUES < INDEX_REACH) ? NUM_QUEUES : INDEX_REACH;
    localparam int DATA_W      = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Item kinds carried on s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    // Access request from the controller to the count store
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [COUNT_W-1:0] wr_data;
        logic [ADDR_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

@@ rtl/jsq_count_ram.sv @@
// Queue occupancy store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on jsq_pkg.
module jsq_count_ram (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  jsq_pkg::ram_req_t        req,
    output logic [jsq_pkg::COUNT_W-1:0] rd_data
);
    import jsq_pkg::*;

    logic [COUNT_W-1:0]    mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] valid_reg;
    logic [COUNT_W-1:0]    rd_word_reg;
    logic                  rd_valid_reg;

    // Storage array, no reset
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_word_reg <= mem[req.rd_addr];
    end

    // Valid bits: cleared by reset, set on first write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

@@ rtl/jsq_ctrl.sv @@
// Dispatch sequencer: applies loads, scans the counts for the shortest
// queue, writes back the increment and holds the result item.
// Depends on jsq_pkg.
module jsq_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [jsq_pkg::CFG_W-1:0]    span,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_op,
    input  logic [jsq_pkg::QUEUE_W-1:0]  in_queue,
    input  logic [jsq_pkg::COUNT_W-1:0]  in_count,
    output jsq_pkg::ram_req_t            req,
    input  logic [jsq_pkg::COUNT_W-1:0]  rd_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [jsq_pkg::QUEUE_W-1:0]  out_queue,
    output logic [jsq_pkg::COUNT_W-1:0]  out_count,
    output logic                         out_sat
);
    import jsq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [QUEUE_W-1:0] k_reg, k_next;
    logic [COUNT_W-1:0] best_reg, best_next;
    logic [QUEUE_W-1:0] best_idx_reg, best_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [QUEUE_W-1:0] out_queue_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_sat_reg;

    logic take, last, commit, sat, accept, load_ok;

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign load_ok = (32'(in_queue) < 32'(NUM_QUEUES));
    assign take    = (k_reg == '0) || (rd_data < best_reg);
    assign last    = (CFG_W'(k_reg) == span - CFG_W'(1));
    assign sat     = (best_reg == COUNT_MAX);
    assign commit  = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_op == OP_ARRIVE) begin
                    k_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one stored count compared per cycle
                if (take) begin
                    best_next     = rd_data;
                    best_idx_next = k_reg;
                end
                if (last) begin
                    state_next = ST_COMMIT;
                end else begin
                    k_next = k_reg + QUEUE_W'(1);
                end
            end
            ST_COMMIT: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Store access: load write, increment write-back, scan read
    always_comb begin
        req.wr_en   = 1'b0;
        req.wr_addr = ADDR_W'(in_queue);
        req.wr_data = in_count;
        req.rd_addr = '0;
        if (accept && in_op == OP_LOAD && load_ok) begin
            req.wr_en = 1'b1;
        end else if (commit && !sat) begin
            req.wr_en   = 1'b1;
            req.wr_addr = ADDR_W'(best_idx_reg);
            req.wr_data = best_reg + COUNT_W'(1);
        end
        if (state_reg == ST_SCAN) begin
            req.rd_addr = ADDR_W'(k_reg + QUEUE_W'(1));
        end
    end

    // Result hold register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        if (commit) begin
            out_queue_reg <= best_idx_reg;
            out_count_reg <= best_reg;
            out_sat_reg   <= sat;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_queue = out_queue_reg;
    assign out_count = out_count_reg;
    assign out_sat   = out_sat_reg;

endmodule

@@ rtl/join_shortest_queue_dispatch.sv @@
// Join-shortest-queue dispatcher, top level.
// Input items arrive on s_*, one result item per arrival leaves on m_*.
// A load item (s_tuser = 0) writes one queue's count and gives no
// result. An arrival item (s_tuser = 1) scans the active queues one
// count per cycle through the single read port of the count store,
// and takes no new item until its result is committed; span is
// active_queues clamped to 1..128, the number of queues scanned.
// The chosen count is incremented (saturating, flagged on m_tuser) and
// written back in the same cycle the result is loaded into the output
// register.
// Reset (aresetn low, synchronous) clears every count to zero and sets
// active_queues to 128. active_queues is written through cfg_wen/cfg_wdata
// by the user only while the block is idle; the block does not enforce it.
// If the receiver stalls, the result waits in the output register; a new
// item can be taken meanwhile, but a second arrival holds before its
// write-back until the first result has gone.
// Depends on jsq_pkg, jsq_count_ram and jsq_ctrl.
module join_shortest_queue_dispatch (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [jsq_pkg::CFG_W-1:0]   cfg_wdata,   // active_queues
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [jsq_pkg::DATA_W-1:0]  s_tdata,     // [6:0] load_queue, [22:7] load_count
    input  logic                        s_tuser,     // [0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [jsq_pkg::DATA_W-1:0]  m_tdata,     // [6:0] chosen_queue, [22:7] length_before_join
    output logic                        m_tuser      // [0] saturated
);
    import jsq_pkg::*;

    logic [CFG_W-1:0]   active_reg;
    logic [CFG_W-1:0]   span;
    ram_req_t           req;
    logic [COUNT_W-1:0] rd_data;
    logic [QUEUE_W-1:0] out_queue;
    logic [COUNT_W-1:0] out_count;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= CFG_W'(INDEX_REACH);
        end else if (cfg_wen) begin
            active_reg <= cfg_wdata;
        end
    end

    // Search span: zero counts as one, capped at the store depth
    always_comb begin
        if (active_reg == '0) begin
            span = CFG_W'(1);
        end else if (active_reg > CFG_W'(SPAN_MAX)) begin
            span = CFG_W'(SPAN_MAX);
        end else begin
            span = active_reg;
        end
    end

    jsq_count_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data)
    );

    jsq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .span      (span),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_queue  (s_tdata[QUEUE_W-1:0]),
        .in_count  (s_tdata[QUEUE_W+COUNT_W-1:QUEUE_W]),
        .req       (req),
        .rd_data   (rd_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_queue (out_queue),
        .out_count (out_count),
        .out_sat   (m_tuser)
    );

    assign m_tdata = {{(DATA_W-QUEUE_W-COUNT_W){1'b0}}, out_count, out_queue};

endmodule
